/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and codes shared by the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Command codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  localparam logic [7:0]  RESET_COLOR = 8'h07;
  localparam logic [15:0] BLANK_CELL  = {RESET_COLOR, CH_SPACE};

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
  } req_t;

  typedef struct packed {
    logic [15:0] cursor_pos;
    logic [15:0] cell_word;
    logic        scrolled;
    logic        bad_position;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_FILL
  } state_t;

endpackage

`default_nettype wire

/* design/text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console: ROWS x COLS screen of 16-bit cells in one synchronous RAM,
// with a write cursor, direct cell writes and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (request) is taken at a clock edge with start
//   high and busy low. One response per item appears for exactly one cycle,
//   marked by done; the receiver cannot stall it.
//   Config channel: cfg_data (attribute byte) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high.
//   Flow: an accepted item goes to the execute state. Put, write and unused
//   commands raise done as the block returns to idle, and the next item can
//   be accepted there. A read also passes through a read state to wait for
//   the RAM read port. A put that runs past the last row scrolls: the screen
//   copy goes through the single RAM read and write port one cell per cycle,
//   then the bottom line is filled with spaces in the current color.
//   Reset: the cursor goes home, the color returns to 0x07 and busy stays
//   high while a clearing pass writes a grey space into every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire tcw_pkg::req_t   request,
  output logic                 done,
  output tcw_pkg::rsp_t        response,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [7:0]            cfg_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS + 8);

  localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END      = AW'(CELLS - COLS);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] COLS_A        = AW'(COLS);
  localparam logic [CW-1:0] COLS_C        = CW'(COLS);
  localparam logic [8:0]    COLS_9        = 9'(COLS);
  localparam logic [8:0]    ROWS_9        = 9'(ROWS);

  // Screen RAM
  logic [15:0]   screen [CELLS];
  logic [15:0]   mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  tcw_pkg::state_t state, state_next;

  logic [7:0]    text_color;
  tcw_pkg::req_t cmd;
  logic [AW-1:0] base, base_next;
  logic [CW-1:0] col, col_next;
  logic [AW-1:0] sweep, sweep_next;
  logic          copy_pend, copy_pend_next;
  logic [AW-1:0] copy_addr, copy_addr_next;
  logic          done_next;
  tcw_pkg::rsp_t response_next;

  // Put-char outcome
  logic [CW-1:0] col_raw;
  logic          put_nl;
  logic          put_wr;
  logic          put_scroll;
  logic [CW-1:0] put_col;
  logic [AW-1:0] put_base;
  logic [15:0]   put_loc;
  logic [15:0]   cur_loc;

  // Direct cell access
  logic          on_screen;
  logic [16:0]   cell_prod;
  logic [AW-1:0] cell_addr;

  assign busy      = (state != tcw_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= screen[mem_raddr];
    end
  end

  always_comb begin
    col_raw = col;
    put_nl  = 1'b0;
    put_wr  = 1'b0;
    case (cmd.char_code)
      tcw_pkg::CH_BS: begin
        if (col != '0) begin
          col_raw = col - CW'(1);
        end
      end
      tcw_pkg::CH_TAB: begin
        col_raw = CW'(col + CW'(8)) & ~CW'(7);
      end
      tcw_pkg::CH_CR: begin
        col_raw = '0;
      end
      tcw_pkg::CH_LF: begin
        col_raw = '0;
        put_nl  = 1'b1;
      end
      default: begin
        if (cmd.char_code >= tcw_pkg::CH_SPACE && cmd.char_code <= tcw_pkg::CH_DEL) begin
          put_wr  = 1'b1;
          col_raw = col + CW'(1);
        end
      end
    endcase
    // wrap past the last column
    if (col_raw >= COLS_C) begin
      col_raw = '0;
      put_nl  = 1'b1;
    end
    put_col    = col_raw;
    put_scroll = put_nl && (base == LAST_ROW_BASE);
    put_base   = (put_nl && !put_scroll) ? base + COLS_A : base;
  end

  assign put_loc = 16'(put_base + AW'(put_col));
  assign cur_loc = 16'(base + AW'(col));

  assign on_screen = (9'(cmd.cell_x) < COLS_9) && (9'(cmd.cell_y) < ROWS_9);
  assign cell_prod = 17'(cmd.cell_y) * 17'(COLS) + 17'(cmd.cell_x);
  assign cell_addr = cell_prod[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    base_next      = base;
    col_next       = col;
    sweep_next     = sweep;
    copy_pend_next = copy_pend;
    copy_addr_next = copy_addr;
    done_next      = 1'b0;
    response_next  = response;
    mem_we         = 1'b0;
    mem_waddr      = sweep;
    mem_wdata      = tcw_pkg::BLANK_CELL;
    mem_re         = 1'b0;
    mem_raddr      = cell_addr;

    case (state)
      tcw_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (sweep == LAST_CELL) begin
          state_next = tcw_pkg::S_IDLE;
        end else begin
          sweep_next = sweep + AW'(1);
        end
      end

      tcw_pkg::S_IDLE: begin
        if (start) begin
          state_next = tcw_pkg::S_EXEC;
        end
      end

      tcw_pkg::S_EXEC: begin
        response_next.cursor_pos   = cur_loc;
        response_next.cell_word    = '0;
        response_next.scrolled     = 1'b0;
        response_next.bad_position = 1'b0;
        state_next                 = tcw_pkg::S_IDLE;
        done_next                  = 1'b1;
        case (cmd.func)
          tcw_pkg::FUNC_PUT: begin
            mem_we    = put_wr;
            mem_waddr = base + AW'(col);
            mem_wdata = {text_color, cmd.char_code};
            col_next  = put_col;
            base_next = put_base;
            response_next.cursor_pos = put_loc;
            if (put_scroll) begin
              // hold the result until the screen has moved up
              done_next      = 1'b0;
              state_next     = tcw_pkg::S_SCROLL;
              sweep_next     = '0;
              copy_pend_next = 1'b0;
            end
          end
          tcw_pkg::FUNC_WRITE: begin
            mem_we    = on_screen;
            mem_waddr = cell_addr;
            mem_wdata = {cmd.cell_color, cmd.char_code};
            response_next.bad_position = !on_screen;
          end
          tcw_pkg::FUNC_READ: begin
            response_next.bad_position = !on_screen;
            if (on_screen) begin
              mem_re     = 1'b1;
              done_next  = 1'b0;
              state_next = tcw_pkg::S_READ;
            end
          end
          default: begin
          end
        endcase
      end

      tcw_pkg::S_READ: begin
        response_next.cell_word = mem_rdata;
        done_next               = 1'b1;
        state_next              = tcw_pkg::S_IDLE;
      end

      tcw_pkg::S_SCROLL: begin
        // write back the previously read cell, one row up
        mem_we    = copy_pend;
        mem_waddr = copy_addr;
        mem_wdata = mem_rdata;
        if (sweep != COPY_END) begin
          mem_re         = 1'b1;
          mem_raddr      = sweep + COLS_A;
          copy_pend_next = 1'b1;
          copy_addr_next = sweep;
          sweep_next     = sweep + AW'(1);
        end else begin
          copy_pend_next = 1'b0;
          state_next     = tcw_pkg::S_FILL;
        end
      end

      tcw_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color, tcw_pkg::CH_SPACE};
        if (sweep == LAST_CELL) begin
          response_next.cursor_pos   = cur_loc;
          response_next.cell_word    = '0;
          response_next.scrolled     = 1'b1;
          response_next.bad_position = 1'b0;
          done_next                  = 1'b1;
          state_next                 = tcw_pkg::S_IDLE;
        end else begin
          sweep_next = sweep + AW'(1);
        end
      end

      default: begin
        state_next = tcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      col        <= '0;
      sweep      <= '0;
      copy_pend  <= 1'b0;
      done       <= 1'b0;
      text_color <= tcw_pkg::RESET_COLOR;
    end else begin
      base      <= base_next;
      col       <= col_next;
      sweep     <= sweep_next;
      copy_pend <= copy_pend_next;
      done      <= done_next;
      if (cfg_valid && cfg_ready) begin
        text_color <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= copy_addr_next;
    response  <= response_next;
    if (state == tcw_pkg::S_IDLE && start) begin
      cmd <= request;
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response strobe while a command is still running");

  a_col_range: assert property (@(posedge clk) disable iff (rst) col < COLS_C)
    else $error("cursor column beyond the last column");

  a_base_range: assert property (@(posedge clk) disable iff (rst) base <= LAST_ROW_BASE)
    else $error("cursor row beyond the last row");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_copy_scroll: assert property (@(posedge clk) disable iff (rst)
    copy_pend |-> (state == tcw_pkg::S_SCROLL))
    else $error("pending copy write outside the scroll pass");
`endif

endmodule

`default_nettype wire
